// ===== rtl/bnc3_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bnc3_pkg
// Shared types and constants of the 3x3 binary neighbour counter.
// ---------------------------------------------------------------------------
package bnc3_pkg;

  // configuration register indexes
  localparam logic [0:0] REG_FRAME_COLS = 1'd0;
  localparam logic [0:0] REG_FRAME_ROWS = 1'd1;

  localparam int CFG_W = 5;

  // entries in the job queue between front and back
  localparam int JOB_DEPTH = 4;

  // which results one pixel calls for
  typedef struct packed {
    logic emit_a;  // count of the position up and to the left
    logic emit_b;  // count of the position straight up (last column)
    logic flush;   // counts of the whole final row
  } job_flags_t;

endpackage

// ===== rtl/bnc3_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bnc3_front
// Tracks the raster position, keeps the three row stores and classifies
// each accepted pixel into a job for the back end.
// ---------------------------------------------------------------------------
module bnc3_front #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 16,
  parameter int CW = $clog2(MAX_COLS),
  parameter int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic                     pixel_bit,
  input  logic [CW:0]              ncols,
  input  logic [RW:0]              nrows,
  output logic                     job_push,
  output bnc3_pkg::job_flags_t     job_flags,
  output logic [MAX_COLS-1:0]      job_old,
  output logic [MAX_COLS-1:0]      job_mid,
  output logic [MAX_COLS-1:0]      job_cur,
  output logic [RW-1:0]            job_row,
  output logic [CW-1:0]            job_col
);

  logic [MAX_COLS-1:0] old_row;
  logic [MAX_COLS-1:0] mid_row;
  logic [MAX_COLS-1:0] cur_row;
  logic [RW-1:0]       row_pos;
  logic [CW-1:0]       col_pos;

  logic [MAX_COLS-1:0] old_row_next;
  logic [MAX_COLS-1:0] mid_row_next;
  logic [MAX_COLS-1:0] cur_row_next;
  logic [RW-1:0]       row_pos_next;
  logic [CW-1:0]       col_pos_next;

  logic [CW-1:0] c_eff;
  logic [RW-1:0] r_eff;
  logic [RW:0]   r_wrap;
  logic [CW:0]   c_inc;
  logic [RW:0]   r_inc;
  logic          last_col;
  logic          last_row;

  always_comb begin
    // fold a position left out of range by a register write
    if ({1'b0, col_pos} >= ncols) begin
      c_eff  = '0;
      r_wrap = {1'b0, row_pos} + 1'b1;
    end else begin
      c_eff  = col_pos;
      r_wrap = {1'b0, row_pos};
    end
    r_eff = (r_wrap >= nrows) ? '0 : r_wrap[RW-1:0];

    last_col = ({1'b0, c_eff} == ncols - 1'b1);
    last_row = ({1'b0, r_eff} == nrows - 1'b1);

    // shift rows at the start of a line, clear them at frame start
    if (c_eff == '0) begin
      old_row_next = (r_eff == '0) ? '0 : mid_row;
      mid_row_next = (r_eff == '0) ? '0 : cur_row;
      cur_row_next = '0;
    end else begin
      old_row_next = old_row;
      mid_row_next = mid_row;
      cur_row_next = cur_row;
    end
    cur_row_next[c_eff] = cur_row_next[c_eff] | pixel_bit;

    // advance the raster position
    c_inc = {1'b0, c_eff} + 1'b1;
    r_inc = {1'b0, r_eff} + 1'b1;
    if (c_inc >= ncols) begin
      col_pos_next = '0;
      row_pos_next = (r_inc >= nrows) ? '0 : r_inc[RW-1:0];
    end else begin
      col_pos_next = c_inc[CW-1:0];
      row_pos_next = r_eff;
    end
  end

  assign job_flags.emit_a = (r_eff != '0) && (c_eff != '0);
  assign job_flags.emit_b = (r_eff != '0) && last_col;
  assign job_flags.flush  = last_row && last_col;
  assign job_push = accept && (job_flags.emit_a || job_flags.emit_b || job_flags.flush);
  assign job_old  = old_row_next;
  assign job_mid  = mid_row_next;
  assign job_cur  = cur_row_next;
  assign job_row  = r_eff;
  assign job_col  = c_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      old_row <= '0;
      mid_row <= '0;
      cur_row <= '0;
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      old_row <= old_row_next;
      mid_row <= mid_row_next;
      cur_row <= cur_row_next;
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

endmodule

// ===== rtl/bnc3_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bnc3_queue
// Small first-in first-out job queue between front and back end.
// ---------------------------------------------------------------------------
module bnc3_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty,
  output logic             is_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;

  assign rd_data   = mem[rd_ptr];
  assign not_empty = (fill != '0);
  assign is_full   = (fill == NW'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        fill <= fill + 1'b1;
      end else if (rd && !wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) is_full |-> !wr)
    else $error("job queue written while full");
  assert property (@(posedge clk) disable iff (rst) !not_empty |-> !rd)
    else $error("job queue read while empty");
  assert property (@(posedge clk) disable iff (rst) fill <= NW'(DEPTH))
    else $error("job queue fill count out of range");

endmodule

// ===== rtl/bnc3_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bnc3_back
// Expands the job at the queue head into counts, one per cycle while the
// output register is free or popped, holding each count there until taken.
// ---------------------------------------------------------------------------
module bnc3_back #(
  parameter int MAX_COLS = 16,
  parameter int CW = $clog2(MAX_COLS),
  parameter int RW = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  bnc3_pkg::job_flags_t job_flags,
  input  logic [MAX_COLS-1:0]  job_old,
  input  logic [MAX_COLS-1:0]  job_mid,
  input  logic [MAX_COLS-1:0]  job_cur,
  input  logic [RW-1:0]        job_row,
  input  logic [CW-1:0]        job_col,
  input  logic [CW:0]          ncols,
  output logic                 job_pop,
  input  logic                 pop,
  output logic                 empty,
  output logic [3:0]           neighbour_count,
  output logic [3:0]           out_row,
  output logic [3:0]           out_col,
  output logic                 last_of_run,
  output logic                 frame_end
);

  logic          done_a;
  logic          done_b;
  logic [CW-1:0] fx;
  logic          out_valid;

  logic                ph_a;
  logic                ph_b;
  logic                ph_f;
  logic                is_last;
  logic                emit;
  logic [CW-1:0]       sel_col;
  logic [RW-1:0]       sel_row;
  logic [MAX_COLS-1:0] r_up;
  logic [MAX_COLS-1:0] r_mid;
  logic [MAX_COLS-1:0] r_dn;
  logic [3:0]          cnt;
  logic [RW+3:0]       row_ext;
  logic [CW+3:0]       col_ext;

  function automatic logic [3:0] count3x3(
    input logic [MAX_COLS-1:0] up,
    input logic [MAX_COLS-1:0] md,
    input logic [MAX_COLS-1:0] dn,
    input logic [CW-1:0]       col,
    input logic [CW:0]         nc
  );
    logic          has_l;
    logic          has_r;
    logic [CW-1:0] cl;
    logic [CW:0]   cr_w;
    logic [CW-1:0] cr;
    logic [3:0]    n;
    has_l = (col != '0);
    cr_w  = {1'b0, col} + 1'b1;
    has_r = (cr_w < nc);
    cl    = col - 1'b1;
    cr    = cr_w[CW-1:0];
    n = 4'({3'b0, up[col]}) + 4'({3'b0, dn[col]});
    if (has_l) begin
      n = n + 4'({3'b0, up[cl]}) + 4'({3'b0, md[cl]}) + 4'({3'b0, dn[cl]});
    end
    if (has_r) begin
      n = n + 4'({3'b0, up[cr]}) + 4'({3'b0, md[cr]}) + 4'({3'b0, dn[cr]});
    end
    return n;
  endfunction

  always_comb begin
    // pick the step of the head job still to be done
    ph_a = job_flags.emit_a && !done_a;
    ph_b = !ph_a && job_flags.emit_b && !done_b;
    ph_f = !ph_a && !ph_b;

    if (ph_a) begin
      is_last = !job_flags.emit_b && !job_flags.flush;
    end else if (ph_b) begin
      is_last = !job_flags.flush;
    end else begin
      is_last = ({1'b0, fx} == ncols - 1'b1);
    end

    if (ph_a) begin
      sel_col = job_col - 1'b1;
    end else if (ph_b) begin
      sel_col = job_col;
    end else begin
      sel_col = fx;
    end
    sel_row = ph_f ? job_row : job_row - 1'b1;

    // the final row sees an empty row below it
    if (ph_f) begin
      r_up  = job_mid;
      r_mid = job_cur;
      r_dn  = '0;
    end else begin
      r_up  = job_old;
      r_mid = job_mid;
      r_dn  = job_cur;
    end

    cnt     = count3x3(r_up, r_mid, r_dn, sel_col, ncols);
    row_ext = {4'b0, sel_row};
    col_ext = {4'b0, sel_col};
  end

  assign emit    = job_valid && (!out_valid || pop);
  assign job_pop = emit && is_last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      done_a    <= 1'b0;
      done_b    <= 1'b0;
      fx        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        if (is_last) begin
          done_a <= 1'b0;
          done_b <= 1'b0;
          fx     <= '0;
        end else if (ph_a) begin
          done_a <= 1'b1;
        end else if (ph_b) begin
          done_b <= 1'b1;
        end else begin
          fx <= fx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      neighbour_count <= cnt;
      out_row         <= row_ext[3:0];
      out_col         <= col_ext[3:0];
      last_of_run     <= is_last;
      frame_end       <= ph_f && is_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job_flags.emit_a || job_flags.emit_b || job_flags.flush))
    else $error("queued job calls for no result");
  assert property (@(posedge clk) disable iff (rst)
    (job_valid && ph_f) |-> ({1'b0, fx} < ncols))
    else $error("flush column ran past the row");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> last_of_run)
    else $error("frame end without end of run");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid)
    else $error("waiting count dropped");

endmodule

// ===== rtl/binary_neighbour_count_3x3_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// binary_neighbour_count_3x3_core
// Eight-neighbour count over a binary image streamed in raster order.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive pixel_bit with push high; a beat is taken at an edge where
//   full is low. Pixels follow raster order over frame_cols x frame_rows.
//   Output: while empty is low, the oldest count sits on neighbour_count,
//   out_row and out_col; raise pop to take it. last_of_run marks the last
//   count caused by one pixel, frame_end the count of the frame's final
//   position.
//   A position's count leaves once its lower-right neighbour is in (the
//   pixel below for the last column); the last pixel of a frame flushes the
//   whole final row, one count per column in a burst.
//   Throughput: one pixel per cycle while full is low. The back end issues
//   one count per cycle while its output register is free or being popped;
//   a job queue of four entries soaks up the extra counts at the end of a
//   line and the final-row burst, and full rises when it fills. A pixel's job
//   enters the queue at the edge that takes it; its counts are then registered.
//   Reset (rst, synchronous): registers go to 10 x 10, the row stores clear,
//   the position returns to row 0, column 0; job queue and output empty.
//   A stalled receiver holds the output register; the back end then waits,
//   the job queue fills, and full stops the source.
//   Register writes (wr_en, wr_index, wr_data) take effect at once; write
//   only while no counts are pending.
// ---------------------------------------------------------------------------
module binary_neighbour_count_3x3_core #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       pixel_bit,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] neighbour_count,
  output logic [3:0] out_row,
  output logic [3:0] out_col,
  output logic       last_of_run,
  output logic       frame_end,
  input  logic       wr_en,
  input  logic [0:0] wr_index,
  input  logic [bnc3_pkg::CFG_W-1:0] wr_data
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int FLW = $bits(bnc3_pkg::job_flags_t);
  localparam int QW  = FLW + 3 * MAX_COLS + RW + CW;
  // limit compares run at the wider of register and count widths
  localparam int CLW = (CW + 1 > bnc3_pkg::CFG_W) ? CW + 1 : bnc3_pkg::CFG_W;
  localparam int RLW = (RW + 1 > bnc3_pkg::CFG_W) ? RW + 1 : bnc3_pkg::CFG_W;

  logic [bnc3_pkg::CFG_W-1:0] frame_cols;
  logic [bnc3_pkg::CFG_W-1:0] frame_rows;

  logic [CLW-1:0] cols_ext;
  logic [RLW-1:0] rows_ext;
  logic [CLW-1:0] cols_lim;
  logic [RLW-1:0] rows_lim;
  logic [CW:0]    ncols;
  logic [RW:0]    nrows;

  // zero acts as one; anything past the maximum saturates
  always_comb begin
    cols_ext = CLW'(frame_cols);
    rows_ext = RLW'(frame_rows);
    if (cols_ext == '0) begin
      cols_lim = CLW'(1);
    end else if (cols_ext > CLW'(MAX_COLS)) begin
      cols_lim = CLW'(MAX_COLS);
    end else begin
      cols_lim = cols_ext;
    end
    if (rows_ext == '0) begin
      rows_lim = RLW'(1);
    end else if (rows_ext > RLW'(MAX_ROWS)) begin
      rows_lim = RLW'(MAX_ROWS);
    end else begin
      rows_lim = rows_ext;
    end
    ncols = cols_lim[CW:0];
    nrows = rows_lim[RW:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cols <= bnc3_pkg::CFG_W'(10);
      frame_rows <= bnc3_pkg::CFG_W'(10);
    end else if (wr_en) begin
      case (wr_index)
        bnc3_pkg::REG_FRAME_COLS: frame_cols <= wr_data;
        bnc3_pkg::REG_FRAME_ROWS: frame_rows <= wr_data;
        default: ;
      endcase
    end
  end

  // front end: position tracking and job classification
  logic                 accept;
  logic                 f_push;
  bnc3_pkg::job_flags_t f_flags;
  logic [MAX_COLS-1:0]  f_old;
  logic [MAX_COLS-1:0]  f_mid;
  logic [MAX_COLS-1:0]  f_cur;
  logic [RW-1:0]        f_row;
  logic [CW-1:0]        f_col;

  assign accept = push && !full;

  bnc3_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW),
    .RW       (RW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pixel_bit (pixel_bit),
    .ncols     (ncols),
    .nrows     (nrows),
    .job_push  (f_push),
    .job_flags (f_flags),
    .job_old   (f_old),
    .job_mid   (f_mid),
    .job_cur   (f_cur),
    .job_row   (f_row),
    .job_col   (f_col)
  );

  // job queue: decouples pixel intake from count issue
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;
  logic          q_valid;
  logic          q_pop;

  assign q_wdata = {f_flags, f_old, f_mid, f_cur, f_row, f_col};

  bnc3_queue #(
    .WIDTH (QW),
    .DEPTH (bnc3_pkg::JOB_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (f_push),
    .wr_data   (q_wdata),
    .rd        (q_pop),
    .rd_data   (q_rdata),
    .not_empty (q_valid),
    .is_full   (full)
  );

  // back end: unpack the head job and issue its counts
  bnc3_pkg::job_flags_t b_flags;
  logic [MAX_COLS-1:0]  b_old;
  logic [MAX_COLS-1:0]  b_mid;
  logic [MAX_COLS-1:0]  b_cur;
  logic [RW-1:0]        b_row;
  logic [CW-1:0]        b_col;

  assign {b_flags, b_old, b_mid, b_cur, b_row, b_col} = q_rdata;

  bnc3_back #(
    .MAX_COLS (MAX_COLS),
    .CW       (CW),
    .RW       (RW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (q_valid),
    .job_flags       (b_flags),
    .job_old         (b_old),
    .job_mid         (b_mid),
    .job_cur         (b_cur),
    .job_row         (b_row),
    .job_col         (b_col),
    .ncols           (ncols),
    .job_pop         (q_pop),
    .pop             (pop),
    .empty           (empty),
    .neighbour_count (neighbour_count),
    .out_row         (out_row),
    .out_col         (out_col),
    .last_of_run     (last_of_run),
    .frame_end       (frame_end)
  );

endmodule
